### design/mssf_pkg.sv
// ----------------------------------------------------------------------------
// mssf_pkg: shared definitions for the motor sequencer
// Mode, action, fault and cause codes, register indexes and the structs that
// pass between the top level and the sequencer core.
// ----------------------------------------------------------------------------
package mssf_pkg;

   localparam int TimerWidth  = 16;
   localparam int CsrIdxWidth = 8;

   // Mode codes
   localparam logic [2:0] MODE_IDLE     = 3'd0;
   localparam logic [2:0] MODE_STARTING = 3'd1;
   localparam logic [2:0] MODE_RUNNING  = 3'd2;
   localparam logic [2:0] MODE_STOPPING = 3'd3;
   localparam logic [2:0] MODE_FAULT    = 3'd4;

   // Request kinds
   localparam logic [1:0] ACT_TICK     = 2'd0;
   localparam logic [1:0] ACT_BUTTON   = 2'd1;
   localparam logic [1:0] ACT_OVERFLOW = 2'd2;

   // Fault codes
   localparam logic [1:0] FAULT_NONE     = 2'd0;
   localparam logic [1:0] FAULT_EXTERNAL = 2'd1;
   localparam logic [1:0] FAULT_OVERFLOW = 2'd2;

   // Transition causes
   localparam logic [2:0] CAUSE_NONE     = 3'd0;
   localparam logic [2:0] CAUSE_BUTTON   = 3'd1;
   localparam logic [2:0] CAUSE_FAULT    = 3'd2;
   localparam logic [2:0] CAUSE_START_TO = 3'd3;
   localparam logic [2:0] CAUSE_STOP_TO  = 3'd4;
   localparam logic [2:0] CAUSE_RESET    = 3'd5;

   // Configuration register indexes
   localparam logic [CsrIdxWidth-1:0] REG_START_TICKS       = 8'd0;
   localparam logic [CsrIdxWidth-1:0] REG_STOP_TICKS        = 8'd1;
   localparam logic [CsrIdxWidth-1:0] REG_RUN_BLINK_TICKS   = 8'd2;
   localparam logic [CsrIdxWidth-1:0] REG_FAULT_BLINK_TICKS = 8'd3;

   // Configuration reset values
   localparam logic [TimerWidth-1:0] START_TICKS_RST       = 16'd1000;
   localparam logic [TimerWidth-1:0] STOP_TICKS_RST        = 16'd500;
   localparam logic [TimerWidth-1:0] RUN_BLINK_TICKS_RST   = 16'd250;
   localparam logic [TimerWidth-1:0] FAULT_BLINK_TICKS_RST = 16'd100;

   typedef struct packed {
      logic [TimerWidth-1:0] start_ticks;
      logic [TimerWidth-1:0] stop_ticks;
      logic [TimerWidth-1:0] run_blink_ticks;
      logic [TimerWidth-1:0] fault_blink_ticks;
   } mssf_cfg_type;

   typedef struct packed {
      logic [1:0] action;
      logic       fault_line;
   } mssf_item_type;

   typedef struct packed {
      logic [2:0]            mode;
      logic [1:0]            fault_code;
      logic                  fault_seen;
      logic [TimerWidth-1:0] phase_timer;
      logic [TimerWidth-1:0] blink_timer;
      logic                  led;
   } mssf_state_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       motor_on;
      logic       led_on;
      logic [1:0] fault_code;
      logic       moved;
      logic [2:0] cause;
   } mssf_result_type;

endpackage

### design/mssf_core.sv
// ----------------------------------------------------------------------------
// mssf_core: sequencer state and per-request update
// Holds the sequencer state and the result register, and applies one request
// per enabled cycle.
// ----------------------------------------------------------------------------
module mssf_core
   import mssf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  mssf_item_type   item,
   input  mssf_cfg_type    cfg,
   output mssf_result_type result
);

   mssf_state_type  state_ff, state_in;
   mssf_result_type result_ff, result_in;

   logic [2:0]            target;
   logic [2:0]            cause;
   logic                  moved;
   logic                  line_mode_fault;
   logic [TimerWidth-1:0] tick_timer;
   logic                  fire;
   logic [TimerWidth-1:0] dec;

   // The phase timer runs in starting and stopping, the blink timer otherwise.
   always_comb begin
      if (state_ff.mode == MODE_STARTING || state_ff.mode == MODE_STOPPING) begin
         tick_timer = state_ff.phase_timer;
      end else begin
         tick_timer = state_ff.blink_timer;
      end
      fire = (tick_timer <= TimerWidth'(1));
      dec  = tick_timer - TimerWidth'(1);
   end

   always_comb begin
      state_in = state_ff;
      target   = state_ff.mode;
      cause    = CAUSE_NONE;
      moved    = 1'b0;

      if (item.action == ACT_OVERFLOW) begin
         state_in.fault_code = FAULT_OVERFLOW;
         target = MODE_FAULT;
         cause  = CAUSE_FAULT;
         moved  = 1'b1;
      end

      line_mode_fault = moved || (state_ff.mode == MODE_FAULT);
      if (!item.fault_line) begin
         state_in.fault_seen = 1'b0;
      end else if (!state_ff.fault_seen) begin
         state_in.fault_seen = 1'b1;
         if (!line_mode_fault) begin
            state_in.fault_code = FAULT_EXTERNAL;
            target = MODE_FAULT;
            cause  = CAUSE_FAULT;
            moved  = 1'b1;
         end
      end

      if (!moved && item.action == ACT_BUTTON) begin
         unique case (state_ff.mode)
            MODE_IDLE: begin
               target = MODE_STARTING;
               cause  = CAUSE_BUTTON;
               moved  = 1'b1;
            end
            MODE_STARTING, MODE_RUNNING: begin
               target = MODE_STOPPING;
               cause  = CAUSE_BUTTON;
               moved  = 1'b1;
            end
            MODE_FAULT: begin
               if (!item.fault_line) begin
                  state_in.fault_code = FAULT_NONE;
                  state_in.fault_seen = 1'b0;
                  target = MODE_IDLE;
                  cause  = CAUSE_RESET;
                  moved  = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end else if (!moved && item.action == ACT_TICK) begin
         unique case (state_ff.mode)
            MODE_STARTING: begin
               if (fire) begin
                  target = MODE_RUNNING;
                  cause  = CAUSE_START_TO;
                  moved  = 1'b1;
               end else begin
                  state_in.phase_timer = dec;
               end
            end
            MODE_STOPPING: begin
               if (fire) begin
                  target = MODE_IDLE;
                  cause  = CAUSE_STOP_TO;
                  moved  = 1'b1;
               end else begin
                  state_in.phase_timer = dec;
               end
            end
            MODE_RUNNING: begin
               if (fire) begin
                  state_in.led         = ~state_ff.led;
                  state_in.blink_timer = cfg.run_blink_ticks;
               end else begin
                  state_in.blink_timer = dec;
               end
            end
            MODE_FAULT: begin
               if (fire) begin
                  state_in.led         = ~state_ff.led;
                  state_in.blink_timer = cfg.fault_blink_ticks;
               end else begin
                  state_in.blink_timer = dec;
               end
            end
            default: begin
            end
         endcase
      end

      // Entry actions of the new mode; leaving a timed phase clears its timer.
      if (moved) begin
         if (state_ff.mode == MODE_STARTING || state_ff.mode == MODE_STOPPING) begin
            state_in.phase_timer = '0;
         end
         state_in.mode = target;
         state_in.led  = (target != MODE_IDLE);
         unique case (target)
            MODE_STARTING: state_in.phase_timer = cfg.start_ticks;
            MODE_STOPPING: state_in.phase_timer = cfg.stop_ticks;
            MODE_RUNNING:  state_in.blink_timer = cfg.run_blink_ticks;
            MODE_FAULT:    state_in.blink_timer = cfg.fault_blink_ticks;
            default: begin
            end
         endcase
      end

      result_in.mode       = state_in.mode;
      result_in.motor_on   = (state_in.mode == MODE_STARTING) ||
                             (state_in.mode == MODE_RUNNING);
      result_in.led_on     = state_in.led;
      result_in.fault_code = state_in.fault_code;
      result_in.moved      = moved;
      result_in.cause      = cause;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

### design/motor_start_stop_fault_sequencer.sv
// ----------------------------------------------------------------------------
// motor_start_stop_fault_sequencer: motor start/stop sequencer with faults
// Five-mode sequencer (idle, starting, running, stopping, fault) driven by
// tick, button and overflow requests, with a configurable timing register set.
// ----------------------------------------------------------------------------
// Each request is one millisecond tick, button press or event overflow notice,
// together with the present fault line level, and produces exactly one
// response giving the mode, motor drive, LED level, fault code and whether
// and why the mode changed. A request is registered on acceptance and is
// processed into the response register once the response slot is free, so
// one request can be taken every cycle while rsp_tready is high; the rate
// is set by the single state update per cycle in the sequencer core. A
// stalled response holds only the stage behind it: the input register keeps
// one request waiting, and req_tready falls only while both stages are full
// and rsp_tready is low. The timing registers (start, stop, run blink and
// fault blink lengths in ticks) are written through the csr_ port, which is
// always ready; write them only while no request is in flight. Writes to an
// index beyond the last register are ignored.
module motor_start_stop_fault_sequencer
   import mssf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [0] fault_line, [7:1] zero
   input  logic [1:0]             req_tuser,   // [1:0] action

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [2:0] mode, [3] motor_on, [4] led_on, [6:5] fault_code, [7] moved,
   // [10:8] cause, [15:11] zero
   output logic [15:0]            rsp_tdata,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [TimerWidth-1:0]  csr_data
);

   mssf_cfg_type    cfg_ff, cfg_in;
   mssf_item_type   item_ff;
   logic            item_valid_ff, item_valid_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            step_en;
   logic            req_accept;
   mssf_result_type result;

   // The core advances when a request waits and the response slot is free
   // or is being emptied in this cycle.
   assign step_en    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || step_en;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_accept) begin
         item_valid_in = 1'b1;
      end else if (step_en) begin
         item_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (step_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.action     <= req_tuser;
         item_ff.fault_line <= req_tdata[0];
      end
   end

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_START_TICKS:       cfg_in.start_ticks       = csr_data;
            REG_STOP_TICKS:        cfg_in.stop_ticks        = csr_data;
            REG_RUN_BLINK_TICKS:   cfg_in.run_blink_ticks   = csr_data;
            REG_FAULT_BLINK_TICKS: cfg_in.fault_blink_ticks = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_ticks       <= START_TICKS_RST;
         cfg_ff.stop_ticks        <= STOP_TICKS_RST;
         cfg_ff.run_blink_ticks   <= RUN_BLINK_TICKS_RST;
         cfg_ff.fault_blink_ticks <= FAULT_BLINK_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mssf_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, result.cause, result.moved, result.fault_code,
                        result.led_on, result.motor_on, result.mode};

endmodule

### design/mssf_checker.sv
// ----------------------------------------------------------------------------
// mssf_checker: port-level checks for the motor sequencer
// Watches the response channel and checks consistency of the reported fields.
// ----------------------------------------------------------------------------
module mssf_checker
   import mssf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   logic [2:0] mode;
   logic       motor_on;
   logic [1:0] fault_code;
   logic       moved;
   logic [2:0] cause;

   assign mode       = rsp_tdata[2:0];
   assign motor_on   = rsp_tdata[3];
   assign fault_code = rsp_tdata[6:5];
   assign moved      = rsp_tdata[7];
   assign cause      = rsp_tdata[10:8];

   // A response that is not taken stays offered unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_motor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> motor_on == (mode == MODE_STARTING || mode == MODE_RUNNING))
      else $error("motor drive does not match mode");

   a_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !moved |-> cause == CAUSE_NONE)
      else $error("cause reported without a transition");

   // A fault code is held exactly while the sequencer sits in fault.
   a_fault_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (fault_code != FAULT_NONE) == (mode == MODE_FAULT))
      else $error("fault code and mode disagree");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response offered right after reset");

endmodule

bind motor_start_stop_fault_sequencer mssf_checker u_mssf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### test/mssf_response_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssf_response_checker: response checker for the motor sequencer
// Watches the request, response and register channels, keeps its own copy of
// the sequencer state and timing registers, and compares every response with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mssf_response_checker
   import mssf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [15:0]            rsp_tdata,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [TimerWidth-1:0]  csr_data,
   output int                     fail_count,
   output int                     awaited_n,
   output int                     checked_n,
   output int                     moves_n
);

   mssf_cfg_type          timing;
   logic [2:0]            seq_mode;
   logic [1:0]            seq_fault;
   logic                  seq_seen;
   logic [TimerWidth-1:0] phase_left;
   logic [TimerWidth-1:0] blink_left;
   logic                  seq_led;
   mssf_result_type       awaited[$];

   // Mode change with the entry actions of the new mode.
   function automatic void enter_mode(input logic [2:0] next);
      if (seq_mode == MODE_STARTING || seq_mode == MODE_STOPPING) begin
         phase_left = '0;
      end
      seq_mode = next;
      seq_led  = (next != MODE_IDLE);
      case (next)
         MODE_STARTING: begin
            phase_left = timing.start_ticks;
         end
         MODE_RUNNING: begin
            blink_left = timing.run_blink_ticks;
         end
         MODE_STOPPING: begin
            phase_left = timing.stop_ticks;
         end
         MODE_FAULT: begin
            blink_left = timing.fault_blink_ticks;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic mssf_result_type predict_response(input logic [1:0] act,
                                                        input logic line);
      mssf_result_type res;
      logic            moved;
      logic [2:0]      cause;
      moved = 1'b0;
      cause = CAUSE_NONE;

      if (act == ACT_OVERFLOW) begin
         seq_fault = FAULT_OVERFLOW;
         enter_mode(MODE_FAULT);
         moved = 1'b1;
         cause = CAUSE_FAULT;
      end

      // Only a rising fault line counts; a held level does nothing more.
      if (!line) begin
         seq_seen = 1'b0;
      end else if (!seq_seen) begin
         seq_seen = 1'b1;
         if (seq_mode != MODE_FAULT) begin
            seq_fault = FAULT_EXTERNAL;
            enter_mode(MODE_FAULT);
            moved = 1'b1;
            cause = CAUSE_FAULT;
         end
      end

      if (!moved && act == ACT_BUTTON) begin
         case (seq_mode)
            MODE_IDLE: begin
               enter_mode(MODE_STARTING);
               moved = 1'b1;
               cause = CAUSE_BUTTON;
            end
            MODE_STARTING, MODE_RUNNING: begin
               enter_mode(MODE_STOPPING);
               moved = 1'b1;
               cause = CAUSE_BUTTON;
            end
            MODE_FAULT: begin
               if (!line) begin
                  seq_fault = FAULT_NONE;
                  seq_seen  = 1'b0;
                  enter_mode(MODE_IDLE);
                  moved = 1'b1;
                  cause = CAUSE_RESET;
               end
            end
            default: begin
            end
         endcase
      end else if (!moved && act == ACT_TICK) begin
         // A counter at one or zero expires on this tick.
         case (seq_mode)
            MODE_STARTING: begin
               if (phase_left <= 1) begin
                  phase_left = '0;
                  enter_mode(MODE_RUNNING);
                  moved = 1'b1;
                  cause = CAUSE_START_TO;
               end else begin
                  phase_left = phase_left - 1'b1;
               end
            end
            MODE_STOPPING: begin
               if (phase_left <= 1) begin
                  phase_left = '0;
                  enter_mode(MODE_IDLE);
                  moved = 1'b1;
                  cause = CAUSE_STOP_TO;
               end else begin
                  phase_left = phase_left - 1'b1;
               end
            end
            MODE_RUNNING: begin
               if (blink_left <= 1) begin
                  seq_led    = ~seq_led;
                  blink_left = timing.run_blink_ticks;
               end else begin
                  blink_left = blink_left - 1'b1;
               end
            end
            MODE_FAULT: begin
               if (blink_left <= 1) begin
                  seq_led    = ~seq_led;
                  blink_left = timing.fault_blink_ticks;
               end else begin
                  blink_left = blink_left - 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      res.mode       = seq_mode;
      res.motor_on   = (seq_mode == MODE_STARTING || seq_mode == MODE_RUNNING);
      res.led_on     = seq_led;
      res.fault_code = seq_fault;
      res.moved      = moved;
      res.cause      = cause;
      return res;
   endfunction

   function automatic void check_field(input string name, input int want,
                                       input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name,
                  want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : watch
      mssf_result_type want;
      if (reset) begin
         timing.start_ticks       = START_TICKS_RST;
         timing.stop_ticks        = STOP_TICKS_RST;
         timing.run_blink_ticks   = RUN_BLINK_TICKS_RST;
         timing.fault_blink_ticks = FAULT_BLINK_TICKS_RST;
         seq_mode   = MODE_IDLE;
         seq_fault  = FAULT_NONE;
         seq_seen   = 1'b0;
         phase_left = '0;
         blink_left = '0;
         seq_led    = 1'b0;
         awaited.delete();
         fail_count = 0;
         checked_n  = 0;
         moves_n    = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_START_TICKS:       timing.start_ticks       = csr_data;
               REG_STOP_TICKS:        timing.stop_ticks        = csr_data;
               REG_RUN_BLINK_TICKS:   timing.run_blink_ticks   = csr_data;
               REG_FAULT_BLINK_TICKS: timing.fault_blink_ticks = csr_data;
               default: begin
               end
            endcase
         end
         if (req_tvalid && req_tready) begin
            awaited.push_back(predict_response(req_tuser, req_tdata[0]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited.size() == 0) begin
               $display("%0t ns: response with none expected, actual %h", $time,
                        rsp_tdata);
               fail_count++;
            end else begin
               want = awaited.pop_front();
               check_field("mode", int'(want.mode), int'(rsp_tdata[2:0]));
               check_field("motor_on", int'(want.motor_on), int'(rsp_tdata[3]));
               check_field("led_on", int'(want.led_on), int'(rsp_tdata[4]));
               check_field("fault_code", int'(want.fault_code),
                           int'(rsp_tdata[6:5]));
               check_field("moved", int'(want.moved), int'(rsp_tdata[7]));
               check_field("cause", int'(want.cause), int'(rsp_tdata[10:8]));
               check_field("padding", 0, int'(rsp_tdata[15:11]));
               checked_n++;
               if (want.moved) begin
                  moves_n++;
               end
            end
         end
      end
      awaited_n = awaited.size();
   end

endmodule

### test/motor_start_stop_fault_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_start_stop_fault_sequencer_tb: testbench for the motor sequencer
// Drives directed and random request streams through several timing register
// settings with random idling on both sides; a separate checker predicts and
// compares every response.
// ----------------------------------------------------------------------------
module motor_start_stop_fault_sequencer_tb;
   import mssf_pkg::*;

   // The action code that the sequencer does not use; only the fault line
   // is looked at for it.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // Register indexes past the end of the register list. Writes to them must
   // leave every timing register untouched.
   localparam logic [CsrIdxWidth-1:0] REG_PAST_END = 8'd4;
   localparam logic [CsrIdxWidth-1:0] REG_TOP_IDX  = 8'hFF;

   // Generous bound for about 550 requests, plus drains and register writes.
   localparam int CycleLimit = 200000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // [0] fault_line, [7:1] zero
   logic [1:0]             req_tuser;   // [1:0] action
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // [2:0] mode, [3] motor_on, [4] led_on, [6:5] fault_code, [7] moved,
   // [10:8] cause, [15:11] zero
   logic [15:0]            rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [TimerWidth-1:0]  csr_data;

   int fail_count;
   int awaited_n;
   int checked_n;
   int moves_n;

   int cycles = 0;
   int gap_max;       // longest sender pause between requests
   int stall_max;     // longest receiver stall per response
   int sent_n = 0;
   int settings_n = 0;
   logic line_lvl;    // fault line level carried across random requests

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   motor_start_stop_fault_sequencer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   mssf_response_checker resp_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .awaited_n  (awaited_n),
      .checked_n  (checked_n),
      .moves_n    (moves_n)
   );

   function automatic int pick_wait(input int max_wait);
      if (max_wait == 0) begin
         return 0;
      end
      return $urandom_range(max_wait, 0);
   endfunction

   // Response side: after each accepted response, draw a stall length and hold
   // rsp_tready low until it has counted down. With stall_max at zero the
   // receiver never stalls.
   always @(posedge clock) begin : rsp_side
      int n;
      static int hold = 0;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         n = pick_wait(stall_max);
         hold = n;
         rsp_tready <= (n == 0);
      end else if (hold != 0) begin
         hold--;
         rsp_tready <= (hold == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycles, awaited_n);
         $display("== FAIL ==");
         $finish;
      end
   end

   // One request: an optional random pause with tvalid low, then hold the
   // request until the sequencer takes it. Called and left at a rising edge;
   // tvalid stays high after the handshake so back-to-back requests are not
   // broken up.
   task automatic send_request(input logic [1:0] act, input logic line);
      int gap;
      gap = pick_wait(gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {7'b0, line};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_n++;
   endtask

   // Waits until every accepted request has been answered. The checker's
   // count is sampled on the falling edge to stay clear of its update.
   task automatic wait_drained();
      do @(negedge clock); while (awaited_n != 0);
      @(posedge clock);
   endtask

   // Stop sending, let the pipeline empty, then give the latency of the two
   // stages some slack before touching the registers.
   task automatic settle();
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx,
                            input logic [TimerWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_timing(input logic [TimerWidth-1:0] start_len,
                             input logic [TimerWidth-1:0] stop_len,
                             input logic [TimerWidth-1:0] run_blink,
                             input logic [TimerWidth-1:0] fault_blink);
      write_reg(REG_START_TICKS, start_len);
      write_reg(REG_STOP_TICKS, stop_len);
      write_reg(REG_RUN_BLINK_TICKS, run_blink);
      write_reg(REG_FAULT_BLINK_TICKS, fault_blink);
      csr_valid <= 1'b0;
      settings_n++;
   endtask

   // Random traffic shaped like real use: mostly ticks that walk the timed
   // phases and blink the LED, regular button presses, and now and then an
   // overflow notice, an unused action code or a change of the fault line.
   // Halfway through, the sender waits for every response before going on.
   task automatic run_random_requests(input int count);
      int roll;
      logic [1:0] act;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) begin
            req_tvalid <= 1'b0;
            wait_drained();
         end
         roll = $urandom_range(99, 0);
         if (roll < 72) begin
            act = ACT_TICK;
         end else if (roll < 88) begin
            act = ACT_BUTTON;
         end else if (roll < 94) begin
            act = ACT_OVERFLOW;
         end else begin
            act = ACT_UNUSED;
         end
         if ($urandom_range(99, 0) < 4) begin
            line_lvl = ~line_lvl;
         end
         send_request(act, line_lvl);
      end
      settle();
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= ACT_TICK;
      csr_valid  <= 1'b0;
      csr_index  <= REG_START_TICKS;
      csr_data   <= '0;
      gap_max    = 13;
      stall_max  = 13;
      line_lvl   = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with the reset timing: button moves from idle, starting
      // and fault, fault entry, ignored presses and the unused action code.
      send_request(ACT_TICK, 1'b0);      // tick while idle does nothing
      send_request(ACT_BUTTON, 1'b0);    // idle to starting
      send_request(ACT_TICK, 1'b0);
      send_request(ACT_BUTTON, 1'b0);    // starting to stopping
      send_request(ACT_BUTTON, 1'b0);    // a press while stopping is ignored
      send_request(ACT_OVERFLOW, 1'b0);  // overflow enters fault
      send_request(ACT_OVERFLOW, 1'b0);  // overflow again while in fault
      send_request(ACT_TICK, 1'b1);      // line rises in fault: no new move
      send_request(ACT_BUTTON, 1'b1);    // press with the line active: ignored
      send_request(ACT_BUTTON, 1'b0);    // line clear: back to idle
      send_request(ACT_TICK, 1'b1);      // rising line while idle
      send_request(ACT_UNUSED, 1'b0);
      send_request(ACT_BUTTON, 1'b0);
      send_request(ACT_UNUSED, 1'b1);    // unused code with a rising line
      send_request(ACT_OVERFLOW, 1'b1);  // overflow with the line held high
      send_request(ACT_BUTTON, 1'b0);
      settle();

      // Zero lengths expire on the very next tick. Writes past the end of
      // the register list carry all ones and must change nothing.
      set_timing('0, '0, '0, '0);
      write_reg(REG_PAST_END, '1);
      write_reg(REG_TOP_IDX, '1);
      csr_valid <= 1'b0;
      send_request(ACT_BUTTON, 1'b0);    // starting
      send_request(ACT_TICK, 1'b0);      // start phase times out
      send_request(ACT_TICK, 1'b0);      // LED toggles
      send_request(ACT_TICK, 1'b0);
      send_request(ACT_BUTTON, 1'b0);    // running to stopping
      send_request(ACT_TICK, 1'b0);      // stop phase times out
      send_request(ACT_BUTTON, 1'b1);    // fault wins over the press
      send_request(ACT_TICK, 1'b1);      // fault LED blinks
      send_request(ACT_BUTTON, 1'b0);
      settle();

      // Random phases, each with its own timing setting. Short lengths let
      // the timed phases run to completion; the all-ones setting keeps the
      // counters near the top of their range.
      set_timing(16'd1, 16'd1, 16'd1, 16'd1);
      run_random_requests(75);

      gap_max   = 0;
      stall_max = 0;
      set_timing(16'd2, 16'd3, 16'd1, 16'd2);
      run_random_requests(75);

      gap_max   = 13;
      stall_max = 13;
      set_timing(TimerWidth'($urandom_range(6, 1)), TimerWidth'($urandom_range(6, 1)),
                 TimerWidth'($urandom_range(6, 1)), TimerWidth'($urandom_range(6, 1)));
      run_random_requests(75);

      set_timing('1, '1, '1, '1);
      run_random_requests(75);

      gap_max   = 0;
      set_timing(TimerWidth'($urandom_range(12, 1)), TimerWidth'($urandom_range(12, 1)),
                 TimerWidth'($urandom_range(12, 1)), TimerWidth'($urandom_range(12, 1)));
      run_random_requests(75);

      gap_max   = 13;
      stall_max = 0;
      set_timing(TimerWidth'($urandom_range(4, 0)), TimerWidth'($urandom_range(4, 0)),
                 TimerWidth'($urandom_range(4, 0)), TimerWidth'($urandom_range(4, 0)));
      run_random_requests(75);

      stall_max = 13;
      set_timing(16'd1, '1, 16'd2, '1);
      run_random_requests(75);

      // Everything has been answered by now; leave room for anything stray.
      repeat (8) @(posedge clock);
      $display("Sent %0d requests over %0d timing settings.", sent_n, settings_n);
      $display("Checked %0d responses, %0d of them with a mode change.",
               checked_n, moves_n);
      if (fail_count == 0 && awaited_n == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### sim.f
design/mssf_pkg.sv
design/mssf_core.sv
design/motor_start_stop_fault_sequencer.sv
design/mssf_checker.sv
test/mssf_response_checker.sv
test/motor_start_stop_fault_sequencer_tb.sv
